// ===== design/rrsf_pkg.sv =====
package rrsf_pkg;

	// grid geometry
	localparam int GRID_SIZE = 64;
	localparam int POS_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

	// field widths
	localparam int RUN_W   = 7;
	localparam int COORD_W = 6;
	localparam int CHAR_W  = 8;

	localparam logic [CHAR_W-1:0] BARRIER_CHAR  = 8'd88;
	localparam logic [RUN_W-1:0]  RUN_MAX       = 7'd127;
	localparam logic [RUN_W-1:0]  MIN_RUN_RESET = 7'd4;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		logic               is_vertical;
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] end_col;
		logic [COORD_W-1:0] end_row;
		logic               last_of_step;
	} seg_t;

	typedef struct packed {
		logic hit;
		seg_t seg;
	} run_hit_t;

	// saturating run count
	function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] len);
		return (len < RUN_MAX) ? len + RUN_W'(1) : RUN_MAX;
	endfunction

	function automatic logic [COORD_W-1:0] to_coord(input logic [POS_W-1:0] pos);
		return COORD_W'(pos);
	endfunction

	// first cell of a run of len cells ending at end_c, modulo the coordinate width
	function automatic logic [COORD_W-1:0] run_start(input logic [COORD_W-1:0] end_c,
			input logic [RUN_W-1:0] len);
		logic [RUN_W-1:0] t;
		t = RUN_W'(end_c) + RUN_W'(1) - len;
		return t[COORD_W-1:0];
	endfunction

endpackage

// ===== design/raster_run_segment_finder.sv =====
// A segment is registered into the result queue by the request that closes it and leaves from the queue head.
// Throughput: one map character per cycle while the 4-entry result queue has room
// for two segments; segments leave at one per cycle while out_stall is low, so dense
// barrier maps are bounded by the output port.
// Column run lengths sit in a 64-cell ring rotated once per accepted request.
// Reset clears position, all run lengths and the queue; min_run_length returns to 4.
module raster_run_segment_finder (
	input  logic                          clk,
	input  logic                          arst_n,
	// map input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rrsf_pkg::CHAR_W-1:0]   map_char,
	// segment output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_vertical,
	output logic [rrsf_pkg::COORD_W-1:0]  start_col,
	output logic [rrsf_pkg::COORD_W-1:0]  start_row,
	output logic [rrsf_pkg::COORD_W-1:0]  end_col,
	output logic [rrsf_pkg::COORD_W-1:0]  end_row,
	output logic                          last_of_step,
	// min_run_length write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rrsf_pkg::RUN_W-1:0]    cfg_data
);

	logic                         in_accept;
	logic                         bar;
	logic                         last_col;
	logic                         last_row;
	logic [rrsf_pkg::RUN_W-1:0]   min_q;
	logic [rrsf_pkg::RUN_W-1:0]   minlen;
	logic [rrsf_pkg::POS_W-1:0]   row_q;
	logic [rrsf_pkg::POS_W-1:0]   col_q;
	logic [rrsf_pkg::RUN_W-1:0]   row_run_q;
	logic [rrsf_pkg::RUN_W-1:0]   hbump;
	logic [rrsf_pkg::RUN_W-1:0]   hlen;
	logic [rrsf_pkg::COORD_W-1:0] end_c;
	rrsf_pkg::run_hit_t           hhit;
	rrsf_pkg::run_hit_t           vhit;
	logic [1:0]                   push_n;
	rrsf_pkg::seg_t               push_a;
	rrsf_pkg::seg_t               push_b;
	logic                         pop;
	logic                         no_room;
	rrsf_pkg::seg_t               head;

	assign in_stall  = no_room;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign bar      = map_char == rrsf_pkg::BARRIER_CHAR;
	assign last_col = col_q == rrsf_pkg::POS_W'(rrsf_pkg::GRID_SIZE - 1);
	assign last_row = row_q == rrsf_pkg::POS_W'(rrsf_pkg::GRID_SIZE - 1);
	// zero minimum acts as one so empty runs never report
	assign minlen   = (min_q == '0) ? rrsf_pkg::RUN_W'(1) : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= rrsf_pkg::MIN_RUN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_q <= cfg_data;
		end
	end

	// horizontal run: closes on a non-barrier cell or at the row's last column
	assign hbump = rrsf_pkg::run_bump(row_run_q);
	assign hlen  = bar ? hbump : row_run_q;
	assign end_c = bar ? rrsf_pkg::to_coord(col_q)
	                   : rrsf_pkg::to_coord(col_q) - rrsf_pkg::COORD_W'(1);

	always_comb begin
		hhit.hit              = bar ? (last_col && (hbump >= minlen)) : (row_run_q >= minlen);
		hhit.seg.is_vertical  = 1'b0;
		hhit.seg.start_col    = rrsf_pkg::run_start(end_c, hlen);
		hhit.seg.end_col      = end_c;
		hhit.seg.start_row    = rrsf_pkg::to_coord(row_q);
		hhit.seg.end_row      = rrsf_pkg::to_coord(row_q);
		// horizontal goes first; it is last only without a vertical partner
		hhit.seg.last_of_step = !vhit.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			row_run_q <= '0;
		end else if (in_accept) begin
			row_run_q <= (bar && !last_col) ? hbump : '0;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + rrsf_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + rrsf_pkg::POS_W'(1);
			end
		end
	end

	rrsf_col_chain u_col_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (in_accept),
		.bar      (bar),
		.last_row (last_row),
		.minlen   (minlen),
		.row      (row_q),
		.col      (col_q),
		.vhit     (vhit)
	);

	// pack up to two segments per request, horizontal first
	always_comb begin
		push_n = in_accept ? (2'(hhit.hit) + 2'(vhit.hit)) : 2'd0;
		push_a = hhit.hit ? hhit.seg : vhit.seg;
		push_b = vhit.seg;
	end

	assign pop = out_valid && !out_stall;

	rrsf_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.pop       (pop),
		.no_room   (no_room),
		.not_empty (out_valid),
		.head      (head)
	);

	assign is_vertical  = head.is_vertical;
	assign start_col    = head.start_col;
	assign start_row    = head.start_row;
	assign end_col      = head.end_col;
	assign end_row      = head.end_row;
	assign last_of_step = head.last_of_step;

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && last_col) |=> (col_q == '0) && (row_run_q == '0))
		else $error("row end did not wrap column and close run");

	a_gap_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !bar) |=> (row_run_q == '0))
		else $error("row run survived a non-barrier cell");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (!push_a.is_vertical && !push_a.last_of_step
			&& push_b.is_vertical))
		else $error("segment pair out of order");

endmodule

// ===== design/rrsf_cell.sv =====
module rrsf_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [rrsf_pkg::RUN_W-1:0] d,
	output logic [rrsf_pkg::RUN_W-1:0] q
);

	logic [rrsf_pkg::RUN_W-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (en) begin
			len_q <= d;
		end
	end

	assign q = len_q;

endmodule

// ===== design/rrsf_col_chain.sv =====
// Column run lengths live in a ring of cells; cell 0 always holds the
// current column, and the ring rotates one place per accepted request.
module rrsf_col_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       bar,
	input  logic                       last_row,
	input  logic [rrsf_pkg::RUN_W-1:0] minlen,
	input  logic [rrsf_pkg::POS_W-1:0] row,
	input  logic [rrsf_pkg::POS_W-1:0] col,
	output rrsf_pkg::run_hit_t         vhit
);

	logic [rrsf_pkg::RUN_W-1:0]   len   [rrsf_pkg::GRID_SIZE];
	logic [rrsf_pkg::RUN_W-1:0]   head;
	logic [rrsf_pkg::RUN_W-1:0]   vbump;
	logic [rrsf_pkg::RUN_W-1:0]   vlen;
	logic [rrsf_pkg::RUN_W-1:0]   tail;
	logic [rrsf_pkg::COORD_W-1:0] end_r;

	for (genvar i = 0; i < rrsf_pkg::GRID_SIZE; i++) begin : g_cell
		if (i == rrsf_pkg::GRID_SIZE - 1) begin : g_tail
			rrsf_cell u_cell (.clk(clk), .arst_n(arst_n), .en(adv), .d(tail), .q(len[i]));
		end else begin : g_mid
			rrsf_cell u_cell (.clk(clk), .arst_n(arst_n), .en(adv), .d(len[i+1]), .q(len[i]));
		end
	end

	assign head  = len[0];
	assign vbump = rrsf_pkg::run_bump(head);
	assign vlen  = bar ? vbump : head;
	// run closes at the bottom row or at the first non-barrier cell
	assign tail  = (bar && !last_row) ? vbump : '0;
	assign end_r = bar ? rrsf_pkg::to_coord(row)
	                   : rrsf_pkg::to_coord(row) - rrsf_pkg::COORD_W'(1);

	always_comb begin
		vhit.hit              = bar ? (last_row && (vbump >= minlen)) : (head >= minlen);
		vhit.seg.is_vertical  = 1'b1;
		vhit.seg.start_col    = rrsf_pkg::to_coord(col);
		vhit.seg.end_col      = rrsf_pkg::to_coord(col);
		vhit.seg.end_row      = end_r;
		vhit.seg.start_row    = rrsf_pkg::run_start(end_r, vlen);
		vhit.seg.last_of_step = 1'b1;
	end

endmodule

// ===== design/rrsf_out_queue.sv =====
module rrsf_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_n,
	input  rrsf_pkg::seg_t push_a,
	input  rrsf_pkg::seg_t push_b,
	input  logic           pop,
	output logic           no_room,
	output logic           not_empty,
	output rrsf_pkg::seg_t head
);

	rrsf_pkg::seg_t                  mem_q [rrsf_pkg::FIFO_DEPTH];
	logic [rrsf_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [rrsf_pkg::FIFO_PTR_W-1:0] wr_ptr_nx;
	logic [rrsf_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [rrsf_pkg::FIFO_CNT_W-1:0] cnt_q;

	assign wr_ptr_nx = wr_ptr_q + rrsf_pkg::FIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rrsf_pkg::FIFO_PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + rrsf_pkg::FIFO_PTR_W'(pop);
			cnt_q    <= cnt_q + rrsf_pkg::FIFO_CNT_W'(push_n) - rrsf_pkg::FIFO_CNT_W'(pop);
		end
	end

	// keep room for the two segments one request can make
	assign no_room   = cnt_q > rrsf_pkg::FIFO_CNT_W'(rrsf_pkg::FIFO_DEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rrsf_pkg::FIFO_CNT_W'(rrsf_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty result queue");

	a_push_pair_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (cnt_q <= rrsf_pkg::FIFO_CNT_W'(rrsf_pkg::FIFO_DEPTH - 2)))
		else $error("segment pair pushed without room");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |=> not_empty)
		else $error("pushed segment not visible");

endmodule
